@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

@@ rtl/xxh32_pkg.sv @@
// ----------------------------------------------------------------------------
// xxh32 package
// primes, commands and status shared by controller and datapath
// ----------------------------------------------------------------------------
package xxh32_pkg;
    localparam logic [31:0] P1 = 32'd2654435761;
    localparam logic [31:0] P2 = 32'd2246822519;
    localparam logic [31:0] P3 = 32'd3266489917;
    localparam logic [31:0] P4 = 32'd668265263;
    localparam logic [31:0] P5 = 32'd374761393;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_WORD_MUL,
        OP_WORD_ROT,
        OP_BYTE_MUL,
        OP_BYTE_ROT,
        OP_AV1,
        OP_AV2,
        OP_AV3,
        OP_AV4,
        OP_AV5
    } t_op;

    typedef struct packed {
        logic       absorb;
        logic       clear;
        t_op        op;
        logic [3:0] pos;
    } t_cmd;

    typedef struct packed {
        logic       lane_busy;
        logic [3:0] fill;
    } t_stat;
endpackage

@@ rtl/xxh32_datapath.sv @@
// ----------------------------------------------------------------------------
// xxh32 datapath
// stripe buffer, lane rounds one lane at a time and a finish accumulator
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module xxh32_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_seed,
    input  logic [7:0]        i_byte,
    input  xxh32_pkg::t_cmd   i_cmd,
    output xxh32_pkg::t_stat  o_stat,
    output logic [31:0]       o_hash
);
    logic [7:0]  r_buf [16];
    logic [31:0] r_lane [4];
    logic [31:0] r_word [4];
    logic [31:0] r_prod;
    logic [2:0]  r_lane_cnt;
    logic        r_lane_ph;
    logic [3:0]  r_fill;
    logic [31:0] r_total;
    logic        r_long;
    logic [31:0] r_h;
    logic [31:0] r_m;
    logic [31:0] w_word;
    logic [31:0] w_rot;
    logic [31:0] w_merge;
    logic        w_fresh;
    logic [1:0]  w_li;

    function automatic logic [31:0] P1s(input logic [31:0] s);
        return s + xxh32_pkg::P1 + xxh32_pkg::P2;
    endfunction

    assign w_fresh = (r_total == 32'd0) && (r_fill == 4'd0) && !r_long;
    assign w_li    = r_lane_cnt[1:0];
    assign w_word  = {r_buf[i_cmd.pos + 4'd3], r_buf[i_cmd.pos + 4'd2],
                      r_buf[i_cmd.pos + 4'd1], r_buf[i_cmd.pos]};
    assign w_rot   = {r_prod[31-13:0], r_prod[31:32-13]} + 32'd0;
    assign w_merge = {r_lane[0][30:0], r_lane[0][31]} + {r_lane[1][24:0], r_lane[1][31:25]}
                   + {r_lane[2][19:0], r_lane[2][31:20]}
                   + {r_lane[3][13:0], r_lane[3][31:14]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.absorb) begin
            r_buf[r_fill] <= i_byte;
        end
        if (i_cmd.absorb && r_fill == 4'd15) begin
            r_word[0] <= {r_buf[3], r_buf[2], r_buf[1], r_buf[0]};
            r_word[1] <= {r_buf[7], r_buf[6], r_buf[5], r_buf[4]};
            r_word[2] <= {r_buf[11], r_buf[10], r_buf[9], r_buf[8]};
            r_word[3] <= {i_byte, r_buf[14], r_buf[13], r_buf[12]};
        end
        if (!i_rst_n) begin
            r_fill     <= 4'd0;
            r_total    <= 32'd0;
            r_long     <= 1'b0;
            r_lane_cnt <= 3'd0;
            r_lane_ph  <= 1'b0;
            r_lane[0]  <= P1s(32'd0);
            r_lane[1]  <= 32'd0 + xxh32_pkg::P2;
            r_lane[2]  <= 32'd0;
            r_lane[3]  <= 32'd0 - xxh32_pkg::P1;
        end else begin
            if (i_cmd.absorb) begin
                if (w_fresh) begin
                    r_lane[0] <= P1s(i_seed);
                    r_lane[1] <= i_seed + xxh32_pkg::P2;
                    r_lane[2] <= i_seed;
                    r_lane[3] <= i_seed - xxh32_pkg::P1;
                end
                r_fill  <= r_fill + 4'd1;
                r_total <= r_total + 32'd1;
                if (r_fill == 4'd15) begin
                    r_long     <= 1'b1;
                    r_lane_cnt <= 3'd4;
                    r_lane_ph  <= 1'b0;
                end
            end
            if (r_lane_cnt != 3'd0) begin
                if (!r_lane_ph) begin
                    r_prod    <= r_lane[w_li] + r_word[w_li] * xxh32_pkg::P2;
                    r_lane_ph <= 1'b1;
                end else begin
                    r_lane[w_li] <= w_rot * xxh32_pkg::P1;
                    r_lane_ph    <= 1'b0;
                    r_lane_cnt   <= r_lane_cnt - 3'd1;
                end
            end
            if (i_cmd.clear) begin
                r_fill  <= 4'd0;
                r_total <= 32'd0;
                r_long  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            xxh32_pkg::OP_INIT:
                r_h <= (r_long ? w_merge : i_seed + xxh32_pkg::P5) + r_total;
            xxh32_pkg::OP_WORD_MUL: r_m <= r_h + w_word * xxh32_pkg::P3;
            xxh32_pkg::OP_WORD_ROT: r_h <= {r_m[14:0], r_m[31:15]} * xxh32_pkg::P4;
            xxh32_pkg::OP_BYTE_MUL: r_m <= r_h + {24'd0, r_buf[i_cmd.pos]} * xxh32_pkg::P5;
            xxh32_pkg::OP_BYTE_ROT: r_h <= {r_m[20:0], r_m[31:21]} * xxh32_pkg::P1;
            xxh32_pkg::OP_AV1: r_h <= (r_h ^ (r_h >> 15)) * xxh32_pkg::P2;
            xxh32_pkg::OP_AV2: r_h <= r_h ^ (r_h >> 13);
            xxh32_pkg::OP_AV3: r_h <= r_h * xxh32_pkg::P3;
            xxh32_pkg::OP_AV4: r_h <= r_h ^ (r_h >> 16);
            default: r_h <= r_h;
        endcase
    end

    assign o_stat.lane_busy = (r_lane_cnt != 3'd0);
    assign o_stat.fill      = r_fill;
    assign o_hash           = r_h;

    `ASSERT_IMPL(a_no_absorb_full_busy, i_clk, i_rst_n,
        (i_cmd.absorb && r_fill == 4'd15) |-> (r_lane_cnt == 3'd0 || r_lane_cnt == 3'd1))
    `ASSERT_NEVER(a_no_init_busy, i_clk, i_rst_n,
        (i_cmd.op == xxh32_pkg::OP_INIT) && (r_lane_cnt != 3'd0))
    `ASSERT_IMPL(a_clear_empties, i_clk, i_rst_n,
        i_cmd.clear |=> (r_fill == 4'd0 && r_total == 32'd0))
endmodule

@@ rtl/xxh32_ctrl.sv @@
// ----------------------------------------------------------------------------
// xxh32 controller
// accepts bytes, sequences the finish and holds the result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module xxh32_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_last,
    input  logic              i_empty,
    input  xxh32_pkg::t_stat  i_stat,
    input  logic [31:0]       i_hash,
    output xxh32_pkg::t_cmd   o_cmd,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_digest
);
    typedef enum logic [2:0] {
        S_RUN, S_WAIT, S_INIT, S_TAIL, S_AV, S_OUT
    } t_state;

    t_state      r_state;
    logic [3:0]  r_n;
    logic [3:0]  r_pos;
    logic [2:0]  r_av;
    logic        r_ph;
    logic        r_valid;
    logic [31:0] r_digest;
    logic        w_acc;
    logic [3:0]  w_rem;

    assign o_ready = (r_state == S_RUN) && !i_stat.lane_busy;
    assign w_acc   = i_valid && o_ready;
    assign w_rem   = r_n - r_pos;

    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = xxh32_pkg::OP_NONE;
        o_cmd.absorb = w_acc && !i_empty;
        o_cmd.pos    = r_pos;
        case (r_state)
            S_INIT: o_cmd.op = xxh32_pkg::OP_INIT;
            S_TAIL: begin
                if (w_rem >= 4'd4)
                    o_cmd.op = r_ph ? xxh32_pkg::OP_WORD_ROT : xxh32_pkg::OP_WORD_MUL;
                else
                    o_cmd.op = r_ph ? xxh32_pkg::OP_BYTE_ROT : xxh32_pkg::OP_BYTE_MUL;
            end
            S_AV: begin
                case (r_av)
                    3'd0: o_cmd.op = xxh32_pkg::OP_AV1;
                    3'd1: o_cmd.op = xxh32_pkg::OP_AV2;
                    3'd2: o_cmd.op = xxh32_pkg::OP_AV3;
                    default: o_cmd.op = xxh32_pkg::OP_AV4;
                endcase
                o_cmd.clear = (r_av == 3'd3);
            end
            default: o_cmd.op = xxh32_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_valid <= 1'b0;
            r_ph    <= 1'b0;
            r_pos   <= 4'd0;
            r_n     <= 4'd0;
            r_av    <= 3'd0;
        end else begin
            if (r_state == S_OUT && (!r_valid || i_ready)) r_valid <= 1'b1;
            else if (r_valid && i_ready) r_valid <= 1'b0;
            case (r_state)
                S_RUN: if (w_acc && i_last) r_state <= S_WAIT;
                S_WAIT: if (!i_stat.lane_busy) begin
                    r_n     <= i_stat.fill;
                    r_pos   <= 4'd0;
                    r_ph    <= 1'b0;
                    r_av    <= 3'd0;
                    r_state <= S_INIT;
                end
                S_INIT: r_state <= (r_n == 4'd0) ? S_AV : S_TAIL;
                S_TAIL: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_pos <= r_pos + ((w_rem >= 4'd4) ? 4'd4 : 4'd1);
                        if (w_rem == 4'd4 || w_rem == 4'd1) r_state <= S_AV;
                    end
                    r_av <= 3'd0;
                end
                S_AV: begin
                    r_av <= r_av + 3'd1;
                    if (r_av == 3'd3) r_state <= S_OUT;
                end
                S_OUT: if (!r_valid || i_ready) begin
                    r_state <= S_RUN;
                end
                default: r_state <= S_RUN;
            endcase
        end
        if (r_state == S_OUT && (!r_valid || i_ready)) r_digest <= i_hash;
    end

    assign o_valid  = r_valid;
    assign o_digest = r_digest;

    `ASSERT_NEVER(a_ready_outside_run, i_clk, i_rst_n, o_ready && r_state != S_RUN)
    `ASSERT_IMPL(a_last_leaves_run, i_clk, i_rst_n, (w_acc && i_last) |=> (r_state == S_WAIT))
    `ASSERT_NEVER(a_tail_bound, i_clk, i_rst_n, (r_state == S_TAIL) && (r_pos >= r_n))
endmodule

@@ rtl/xxhash32_byte_stream.sv @@
// ----------------------------------------------------------------------------
// xxhash32 byte stream
// xxHash32 digest of a byte message, seed from a configuration write
// ----------------------------------------------------------------------------
// channel     direction  contents
// s_axis      in         tdata[7:0] data_byte, tuser[0] empty_req, tlast last
// m_axis      out        tdata[31:0] digest
// cfg         in         seed[31:0]
//
// input takes a byte whenever ready; a full stripe stalls input while
// the four lanes are updated through one shared multiply and rotate unit.
// the finish folds in the tail words and bytes, runs the avalanche, then the
// result register; reset is synchronous, active low, and clears message state.
// ----------------------------------------------------------------------------
module xxhash32_byte_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,   // empty_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    logic [31:0]       r_seed;
    xxh32_pkg::t_cmd   w_cmd;
    xxh32_pkg::t_stat  w_stat;
    logic [31:0]       w_hash;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_seed <= 32'd0;
        else if (i_cfg_valid) r_seed <= i_cfg_data;
    end

    xxh32_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_seed(r_seed), .i_byte(s_axis_tdata),
        .i_cmd(w_cmd), .o_stat(w_stat), .o_hash(w_hash)
    );

    xxh32_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_last(s_axis_tlast), .i_empty(s_axis_tuser),
        .i_stat(w_stat), .i_hash(w_hash), .o_cmd(w_cmd), .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready), .o_digest(m_axis_tdata)
    );
endmodule

@@ sim/xxhash32_byte_stream_tb.sv @@
// ----------------------------------------------------------------------------
// xxhash32 byte stream testbench
// drives byte messages with random gaps and output stalls, predicts each
// digest in a local model and checks it; the seed is rewritten between phases
// ----------------------------------------------------------------------------
module xxhash32_byte_stream_tb;
    typedef struct {
        logic [7:0] data_byte;
        logic       last;
        logic       empty_req;
        logic       chk;
        logic [31:0] digest;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;

    xxhash32_byte_stream dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    localparam int WATCHDOG = 20000;
    localparam int DRAIN    = 200;

    // local copy of the hash state
    logic [31:0] seed_reg;
    logic [31:0] lane[4];
    logic [7:0]  stripe[16];
    int unsigned fill;
    logic [31:0] total;
    logic        long_msg;

    logic [31:0] digest_q[$];
    logic        check_q[$];
    logic [31:0] known_q[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          hold_off = 0;
    bit          stall_on = 1;
    t_row        dir_rows[$];
    int          items_sent = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic logic [31:0] rotl(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [31:0] word_of(int p);
        return {stripe[(p + 3) & 15], stripe[(p + 2) & 15], stripe[(p + 1) & 15],
                stripe[p & 15]};
    endfunction

    function automatic logic [31:0] lane_mix(logic [31:0] a, logic [31:0] w);
        return rotl(a + w * xxh32_pkg::P2, 13) * xxh32_pkg::P1;
    endfunction

    task automatic predict_digest(input logic [7:0] b, input logic lst, input logic emp);
        logic [31:0] h;
        int p;
        if (!emp) begin
            if (total == 0 && fill == 0 && !long_msg) begin
                lane[0] = seed_reg + xxh32_pkg::P1 + xxh32_pkg::P2;
                lane[1] = seed_reg + xxh32_pkg::P2;
                lane[2] = seed_reg;
                lane[3] = seed_reg - xxh32_pkg::P1;
            end
            stripe[fill] = b;
            fill++;
            total++;
            if (fill == 16) begin
                for (int k = 0; k < 4; k++) lane[k] = lane_mix(lane[k], word_of(4 * k));
                fill = 0;
                long_msg = 1;
            end
        end
        if (lst) begin
            if (long_msg)
                h = rotl(lane[0], 1) + rotl(lane[1], 7) + rotl(lane[2], 12)
                  + rotl(lane[3], 18);
            else
                h = seed_reg + xxh32_pkg::P5;
            h += total;
            p = 0;
            while (p + 4 <= fill) begin
                h += word_of(p) * xxh32_pkg::P3;
                h = rotl(h, 17) * xxh32_pkg::P4;
                p += 4;
            end
            while (p < fill) begin
                h += {24'd0, stripe[p]} * xxh32_pkg::P5;
                h = rotl(h, 11) * xxh32_pkg::P1;
                p++;
            end
            h ^= h >> 15;
            h *= xxh32_pkg::P2;
            h ^= h >> 13;
            h *= xxh32_pkg::P3;
            h ^= h >> 16;
            digest_q.push_back(h);
            fill = 0;
            total = 0;
            long_msg = 0;
        end
    endtask

    // sender side: bursts with random gaps
    task automatic send_item(input logic [7:0] b, input logic lst, input logic emp,
                             input logic chk, input logic [31:0] known);
        if ($urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        s_axis_tuser  <= emp;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_digest(b, lst, emp);
        if (lst) begin
            check_q.push_back(chk);
            known_q.push_back(known);
        end
        @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        s_axis_tvalid <= 1'b0;
        while (digest_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        seed_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_message(input int len, input bit trail_empty);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom), 1'b0, 1'b1, 1'b0, 32'd0);
            send_item(8'($urandom), (k == len - 1) && !trail_empty, 1'b0, 1'b0, 32'd0);
        end
        if (trail_empty || len == 0) send_item(8'($urandom), 1'b1, 1'b1, 1'b0, 32'd0);
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) m_axis_tready <= 1'b0;
        else if (stall_on) m_axis_tready <= ($urandom_range(0, 2) != 0);
        else m_axis_tready <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_q.size() == 0) begin
                $error("unexpected digest %h", m_axis_tdata);
                errors++;
            end else begin
                if (m_axis_tdata !== digest_q[0]) begin
                    $error("digest: expected %h, actual %h", digest_q[0], m_axis_tdata);
                    errors++;
                end
                if (check_q[0] && m_axis_tdata !== known_q[0]) begin
                    $error("digest: expected %h, actual %h", known_q[0], m_axis_tdata);
                    errors++;
                end
                void'(digest_q.pop_front());
                void'(check_q.pop_front());
                void'(known_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || hold_off || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("xxhash32_byte_stream_tb: FAIL");
            $finish;
        end
    end

    // long hold-off on the output while input keeps coming
    initial begin
        wait (items_sent >= 300);
        @(negedge i_clk);
        hold_off = 1;
        repeat (400) @(negedge i_clk);
        hold_off = 0;
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        s_axis_tuser = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        seed_reg = '0;
        fill = 0;
        total = '0;
        long_msg = 0;
        for (int k = 0; k < 16; k++) stripe[k] = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty message with seed 0 has a well-known digest
        dir_rows.push_back('{8'h00, 1'b1, 1'b1, 1'b1, 32'h02cc5d05});
        dir_rows.push_back('{8'hff, 1'b0, 1'b1, 1'b0, 32'd0});
        dir_rows.push_back('{8'h00, 1'b1, 1'b0, 1'b0, 32'd0});
        dir_rows.push_back('{8'hff, 1'b1, 1'b0, 1'b0, 32'd0});
        dir_rows.push_back('{8'h55, 1'b0, 1'b0, 1'b0, 32'd0});
        dir_rows.push_back('{8'haa, 1'b1, 1'b1, 1'b0, 32'd0});
        for (int k = 0; k < 17; k++)
            dir_rows.push_back('{8'(k * 15), k == 16, 1'b0, 1'b0, 32'd0});
        foreach (dir_rows[k])
            send_item(dir_rows[k].data_byte, dir_rows[k].last, dir_rows[k].empty_req,
                      dir_rows[k].chk, dir_rows[k].digest);

        write_seed(32'hffffffff);
        send_message(0, 1'b0);
        send_message(20, 1'b0);
        send_message(3, 1'b1);
        // seed changed mid-message
        send_item(8'h12, 1'b0, 1'b0, 1'b0, 32'd0);
        write_seed(32'h00000000);
        send_item(8'h34, 1'b1, 1'b0, 1'b0, 32'd0);

        while (items_sent < 1000) begin
            int len;
            if (!hold_off && $urandom_range(0, 7) == 0) begin
                write_seed($urandom);
                stall_on = $urandom_range(0, 1);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 80)
                                                 : $urandom_range(0, 35);
            send_message(len, $urandom_range(0, 5) == 0);
            items_sent += len + 1;
        end
        write_seed(32'h9e3779b1);
        send_message(40, 1'b0);
        s_axis_tvalid <= 1'b0;

        while (digest_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        if (errors == 0)
            $display("xxhash32_byte_stream_tb: PASS");
        else
            $display("xxhash32_byte_stream_tb: FAIL");
        $finish;
    end
endmodule

@@ xxhash32_byte_stream.f @@
+incdir+rtl
rtl/xxh32_pkg.sv
rtl/xxh32_datapath.sv
rtl/xxh32_ctrl.sv
rtl/xxhash32_byte_stream.sv
sim/xxhash32_byte_stream_tb.sv
